// ===== sv/mfp_pkg.sv =====
package mfp_pkg;

    // Header layout: two nibble bytes, three 32-bit ids, a 16-byte IV, a 16-bit length.
    localparam int HEADER_BYTES = 2 + 4 + 4 + 4 + 16 + 2;

    // Reset value of the payload length limit.
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Kind of a result item.
    typedef enum logic [2:0] {
        KIND_IV_HI   = 3'd0,
        KIND_IV_LO   = 3'd1,
        KIND_HEADER  = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_ERROR   = 3'd4
    } t_kind;

    // Frame status carried by an error result.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_SHORT_HDR = 2'd2,
        ST_SHORT_PAY = 2'd3
    } t_status;

    // Header fields as they travel through the queue.
    typedef struct packed {
        logic [15:0] nibbles;
        logic [31:0] group_id;
        logic [31:0] sender_id;
        logic [31:0] sequence_number;
        logic [15:0] payload_length;
    } t_hdr;

    // One queue entry: a first result, optionally followed by an error end.
    typedef struct packed {
        t_kind        kind;
        logic         last;
        t_status      status;
        logic         extra;
        t_status      extra_status;
        logic [127:0] data;
    } t_cmd;

    // One result item as it is presented on the output channel.
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  version;
        logic [3:0]  msg_type;
        logic [3:0]  qos;
        logic [3:0]  hops;
        logic [31:0] group_id;
        logic [31:0] sender_id;
        logic [31:0] sequence_number;
        logic [15:0] payload_length;
        logic [63:0] data_word;
        logic        last;
        t_status     status;
    } t_result;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== sv/mfp_front.sv =====
module mfp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_end_of_frame,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  mfp_pkg::t_qstat    i_qstat,
    output logic               o_push,
    output mfp_pkg::t_cmd      o_cmd
);
    import mfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    // Header byte positions that close a field.
    localparam logic [4:0] POS_NIB_END   = 5'd1;
    localparam logic [4:0] POS_GROUP_END = 5'd5;
    localparam logic [4:0] POS_SEND_END  = 5'd9;
    localparam logic [4:0] POS_SEQ_END   = 5'd13;
    localparam logic [4:0] POS_IVHI_END  = 5'd21;
    localparam logic [4:0] POS_IVLO_END  = 5'd29;
    localparam logic [4:0] POS_LAST      = 5'(HEADER_BYTES - 1);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_nib, n_nib;
    logic [31:0] r_gid, n_gid;
    logic [31:0] r_sid, n_sid;
    logic [31:0] r_seq, n_seq;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_max_payload;
    logic        accept;
    logic        iv_done;
    logic [15:0] cnt_inc;
    t_hdr        hdr;

    assign accept  = i_in_valid && !i_qstat.full;
    assign cnt_inc = r_cnt + 16'd1;

    // Classify the byte and form the queue entry it causes.
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_nib   = r_nib;
        n_gid   = r_gid;
        n_sid   = r_sid;
        n_seq   = r_seq;
        n_len   = r_len;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_cmd   = '0;
        iv_done = 1'b0;
        hdr     = '0;
        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    n_acc = {r_acc[55:0], i_rx_byte};
                    if (r_pos <= POS_NIB_END) begin
                        n_nib = {r_nib[7:0], i_rx_byte};
                    end else if (r_pos == POS_GROUP_END) begin
                        n_gid = n_acc[31:0];
                    end else if (r_pos == POS_SEND_END) begin
                        n_sid = n_acc[31:0];
                    end else if (r_pos == POS_SEQ_END) begin
                        n_seq = n_acc[31:0];
                    end else if (r_pos == POS_IVHI_END || r_pos == POS_IVLO_END) begin
                        iv_done    = 1'b1;
                        o_push     = 1'b1;
                        o_cmd.kind = (r_pos == POS_IVHI_END) ? KIND_IV_HI : KIND_IV_LO;
                        o_cmd.data = {64'd0, n_acc};
                    end

                    if (r_pos == POS_LAST) begin
                        // Header complete: check the length and pick the next phase.
                        n_len = n_acc[15:0];
                        n_pos = '0;
                        n_cnt = '0;
                        hdr   = '{nibbles: r_nib, group_id: r_gid, sender_id: r_sid,
                                  sequence_number: r_seq, payload_length: n_acc[15:0]};
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_HEADER;
                        o_cmd.data = hdr;
                        if (n_acc[15:0] > r_max_payload) begin
                            o_cmd.kind   = KIND_ERROR;
                            o_cmd.data   = '0;
                            o_cmd.last   = 1'b1;
                            o_cmd.status = ST_TOO_LONG;
                            n_phase      = i_end_of_frame ? PH_HEADER : PH_DISCARD;
                        end else if (n_acc[15:0] == 16'd0) begin
                            o_cmd.last = 1'b1;
                            n_phase    = i_end_of_frame ? PH_HEADER : PH_DISCARD;
                        end else if (i_end_of_frame) begin
                            o_cmd.extra        = 1'b1;
                            o_cmd.extra_status = ST_SHORT_PAY;
                            n_phase            = PH_HEADER;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else if (i_end_of_frame) begin
                        // Frame ended inside the header.
                        n_pos  = '0;
                        o_push = 1'b1;
                        if (iv_done) begin
                            o_cmd.extra        = 1'b1;
                            o_cmd.extra_status = ST_SHORT_HDR;
                        end else begin
                            o_cmd.kind   = KIND_ERROR;
                            o_cmd.last   = 1'b1;
                            o_cmd.status = ST_SHORT_HDR;
                        end
                    end else begin
                        n_pos = r_pos + 5'd1;
                    end
                end
                PH_PAYLOAD: begin
                    n_cnt      = cnt_inc;
                    o_push     = 1'b1;
                    o_cmd.kind = KIND_PAYLOAD;
                    o_cmd.data = {120'd0, i_rx_byte};
                    if (cnt_inc == r_len) begin
                        o_cmd.last = 1'b1;
                        n_phase    = i_end_of_frame ? PH_HEADER : PH_DISCARD;
                    end else if (i_end_of_frame) begin
                        o_cmd.extra        = 1'b1;
                        o_cmd.extra_status = ST_SHORT_PAY;
                        n_phase            = PH_HEADER;
                    end
                end
                default: begin
                    // Discard until the end of the frame.
                    if (i_end_of_frame) begin
                        n_phase = PH_HEADER;
                        n_pos   = '0;
                    end
                end
            endcase
        end
    end

    // Parser state and the length limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_pos         <= '0;
            r_acc         <= '0;
            r_nib         <= '0;
            r_gid         <= '0;
            r_sid         <= '0;
            r_seq         <= '0;
            r_len         <= '0;
            r_cnt         <= '0;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_nib   <= n_nib;
            r_gid   <= n_gid;
            r_sid   <= n_sid;
            r_seq   <= n_seq;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_max_payload <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ===== sv/mfp_queue.sv =====
module mfp_queue #(
    parameter int DEPTH = mfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mfp_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output mfp_pkg::t_cmd   o_head,
    output mfp_pkg::t_qstat o_qstat
);
    import mfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_qstat.full  = (r_cnt == CNT_FULL);
    assign o_qstat.empty = (r_cnt == '0);
    assign o_head        = r_mem[r_rd];
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== sv/mfp_back.sv =====
module mfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mfp_pkg::t_cmd    i_head,
    input  mfp_pkg::t_qstat  i_qstat,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output mfp_pkg::t_result o_result
);
    import mfp_pkg::*;

    logic    r_valid;
    logic    r_second, n_second;
    t_result r_res, n_res;
    logic    load, take;
    t_hdr    hdr;

    assign load  = !r_valid || !i_out_stall;
    assign take  = load && !i_qstat.empty;
    assign o_pop = take && (r_second || !i_head.extra);
    assign hdr   = t_hdr'(i_head.data);

    // Expand the head entry into the next result item.
    always_comb begin
        n_res    = '0;
        n_second = r_second;
        if (take) begin
            n_second = !r_second && i_head.extra;
        end
        if (r_second) begin
            n_res.kind   = KIND_ERROR;
            n_res.last   = 1'b1;
            n_res.status = i_head.extra_status;
        end else begin
            n_res.kind   = i_head.kind;
            n_res.last   = i_head.last;
            n_res.status = i_head.status;
            case (i_head.kind)
                KIND_HEADER: begin
                    n_res.version         = hdr.nibbles[15:12];
                    n_res.msg_type        = hdr.nibbles[11:8];
                    n_res.qos             = hdr.nibbles[7:4];
                    n_res.hops            = hdr.nibbles[3:0];
                    n_res.group_id        = hdr.group_id;
                    n_res.sender_id       = hdr.sender_id;
                    n_res.sequence_number = hdr.sequence_number;
                    n_res.payload_length  = hdr.payload_length;
                end
                KIND_IV_HI, KIND_IV_LO, KIND_PAYLOAD: begin
                    n_res.data_word = i_head.data[63:0];
                end
                default: begin
                    n_res.data_word = '0;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= take;
            end
            r_second <= n_second;
        end
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_res;

endmodule

// ===== sv/message_frame_parser.sv =====
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall i_rx_byte, i_end_of_frame
// out       output     o_out_valid/i_out_stall o_out_kind ... o_status
// cfg       input      i_cfg_wr_en             i_cfg_wr_data (max_payload)
//
// One input byte is accepted per cycle while o_in_stall is low; the front part
// classifies it in that cycle. Results leave one per cycle through the output register
// while i_out_stall is low. A byte may cause two results (an IV half, header or payload
// byte followed by an error end); the queue of QUEUE_DEPTH entries absorbs such
// bursts and output stalls. o_in_stall is high exactly while the queue is full.
// Reset is synchronous and active low; it clears control state and sets max_payload
// to 1024, and no result is pending after it.
module message_frame_parser #(
    parameter int QUEUE_DEPTH = mfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_frame,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_kind,
    output logic [3:0]  o_version,
    output logic [3:0]  o_msg_type,
    output logic [3:0]  o_qos,
    output logic [3:0]  o_hops,
    output logic [31:0] o_group_id,
    output logic [31:0] o_sender_id,
    output logic [31:0] o_sequence_number,
    output logic [15:0] o_payload_length,
    output logic [63:0] o_data_word,
    output logic        o_last,
    output logic [1:0]  o_status
);
    import mfp_pkg::*;

    t_cmd    push_cmd, head;
    t_qstat  qstat;
    t_result res;
    logic    push, pop;

    assign o_in_stall = qstat.full;

    // Front part: parse bytes into queue entries.
    mfp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Queue between the two parts.
    mfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // Back part: emit result items.
    mfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_result    (res)
    );

    assign o_out_kind        = res.kind;
    assign o_version         = res.version;
    assign o_msg_type        = res.msg_type;
    assign o_qos             = res.qos;
    assign o_hops            = res.hops;
    assign o_group_id        = res.group_id;
    assign o_sender_id       = res.sender_id;
    assign o_sequence_number = res.sequence_number;
    assign o_payload_length  = res.payload_length;
    assign o_data_word       = res.data_word;
    assign o_last            = res.last;
    assign o_status          = res.status;

endmodule

// ===== sv/mfp_checker.sv =====
module mfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_out_kind,
    input logic [3:0]  o_version,
    input logic [3:0]  o_hops,
    input logic [31:0] o_group_id,
    input logic [15:0] o_payload_length,
    input logic [63:0] o_data_word,
    input logic        o_last,
    input logic [1:0]  o_status
);
    import mfp_pkg::*;

    // A stalled result stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_kind)
            && $stable(o_data_word) && $stable(o_last) && $stable(o_status))
        else $error("stalled result changed");

    // An error result ends the frame and carries a failing status.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_ERROR |-> o_last && o_status != ST_OK
            && o_data_word == 64'd0)
        else $error("malformed error result");

    // Only an error result carries a failing status.
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind != KIND_ERROR |-> o_status == ST_OK)
        else $error("status on a non-error result");

    // Header fields appear only in a header result.
    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind != KIND_HEADER |-> o_payload_length == 16'd0
            && o_group_id == 32'd0 && o_version == 4'd0 && o_hops == 4'd0)
        else $error("header fields on a non-header result");

    // A payload result carries one byte in the low bits.
    a_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_PAYLOAD |-> o_data_word[63:8] == 56'd0)
        else $error("payload result wider than a byte");

endmodule

bind message_frame_parser mfp_checker u_mfp_checker (.*);

// ===== test/message_frame_parser_tb.sv =====
module message_frame_parser_tb;

    import mfp_pkg::*;

    // Run length and timing knobs.
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_TIME   = 4_000_000;

    // Parser phase as the predictor tracks it.
    typedef enum logic [1:0] {
        PH_HDR,
        PH_PAY,
        PH_DROP
    } t_parse_phase;

    // Predicts the parser's results from accepted bytes and checks the output against them.
    class frame_scoreboard;
        t_result       expected_results[$];
        int            failures;
        int            live_items;
        logic [15:0]   max_len;
        t_parse_phase  ph;
        logic [4:0]    hdr_pos;
        logic [63:0]   acc;
        logic [15:0]   nibbles;
        logic [31:0]   gid;
        logic [31:0]   sid;
        logic [31:0]   seq;
        logic [15:0]   len;
        logic [15:0]   pcount;

        function new();
            failures   = 0;
            live_items = 0;
            max_len    = MAX_PAYLOAD_RESET;
            ph         = PH_HDR;
            hdr_pos    = '0;
            acc        = '0;
            nibbles    = '0;
            gid        = '0;
            sid        = '0;
            seq        = '0;
            len        = '0;
            pcount     = '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // A result with all fields not owned by its kind left at zero.
        function t_result plain_result(t_kind k, logic [63:0] d, logic lst, t_status st);
            t_result r;
            r           = '0;
            r.kind      = k;
            r.data_word = d;
            r.last      = lst;
            r.status    = st;
            return r;
        endfunction

        function t_result header_result(logic lst);
            t_result r;
            r                 = plain_result(KIND_HEADER, 64'd0, lst, ST_OK);
            r.version         = nibbles[15:12];
            r.msg_type        = nibbles[11:8];
            r.qos             = nibbles[7:4];
            r.hops            = nibbles[3:0];
            r.group_id        = gid;
            r.sender_id       = sid;
            r.sequence_number = seq;
            r.payload_length  = len;
            return r;
        endfunction

        // Advances the parser state by one accepted byte and queues what it should emit.
        function void note_byte(logic [7:0] b, logic eof);
            logic [4:0] pos;
            if (ph == PH_HDR) begin
                live_items++;
                pos = hdr_pos;
                acc = {acc[55:0], b};
                if (pos <= 1) begin
                    nibbles = {nibbles[7:0], b};
                end else if (pos == 5) begin
                    gid = acc[31:0];
                end else if (pos == 9) begin
                    sid = acc[31:0];
                end else if (pos == 13) begin
                    seq = acc[31:0];
                end else if (pos == 21) begin
                    expected_results.push_back(plain_result(KIND_IV_HI, acc, 1'b0, ST_OK));
                end else if (pos == 29) begin
                    expected_results.push_back(plain_result(KIND_IV_LO, acc, 1'b0, ST_OK));
                end

                // The last header byte decides between rejection, header, and payload.
                if (pos == HEADER_BYTES - 1) begin
                    len     = acc[15:0];
                    hdr_pos = '0;
                    pcount  = '0;
                    if (len > max_len) begin
                        expected_results.push_back(
                            plain_result(KIND_ERROR, 64'd0, 1'b1, ST_TOO_LONG));
                        ph = eof ? PH_HDR : PH_DROP;
                    end else if (len == 0) begin
                        expected_results.push_back(header_result(1'b1));
                        ph = eof ? PH_HDR : PH_DROP;
                    end else if (eof) begin
                        expected_results.push_back(header_result(1'b0));
                        expected_results.push_back(
                            plain_result(KIND_ERROR, 64'd0, 1'b1, ST_SHORT_PAY));
                        ph = PH_HDR;
                    end else begin
                        expected_results.push_back(header_result(1'b0));
                        ph = PH_PAY;
                    end
                end else if (eof) begin
                    expected_results.push_back(
                        plain_result(KIND_ERROR, 64'd0, 1'b1, ST_SHORT_HDR));
                    hdr_pos = '0;
                end else begin
                    hdr_pos = pos + 5'd1;
                end
            end else if (ph == PH_PAY) begin
                live_items++;
                pcount = pcount + 16'd1;
                if (pcount == len) begin
                    expected_results.push_back(plain_result(KIND_PAYLOAD, {56'd0, b}, 1'b1, ST_OK));
                    ph = eof ? PH_HDR : PH_DROP;
                end else begin
                    expected_results.push_back(plain_result(KIND_PAYLOAD, {56'd0, b}, 1'b0, ST_OK));
                    if (eof) begin
                        expected_results.push_back(
                            plain_result(KIND_ERROR, 64'd0, 1'b1, ST_SHORT_PAY));
                        ph = PH_HDR;
                    end
                end
            end else if (eof) begin
                // Discarded bytes run up to the end of the frame.
                ph      = PH_HDR;
                hdr_pos = '0;
            end
        endfunction

        function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        // Compares one accepted result with the oldest outstanding prediction.
        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, got.kind);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            cmp_field("out_kind", 64'(want.kind), 64'(got.kind));
            cmp_field("version", 64'(want.version), 64'(got.version));
            cmp_field("msg_type", 64'(want.msg_type), 64'(got.msg_type));
            cmp_field("qos", 64'(want.qos), 64'(got.qos));
            cmp_field("hops", 64'(want.hops), 64'(got.hops));
            cmp_field("group_id", 64'(want.group_id), 64'(got.group_id));
            cmp_field("sender_id", 64'(want.sender_id), 64'(got.sender_id));
            cmp_field("sequence_number", 64'(want.sequence_number),
                      64'(got.sequence_number));
            cmp_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
            cmp_field("data_word", want.data_word, got.data_word);
            cmp_field("last", 64'(want.last), 64'(got.last));
            cmp_field("status", 64'(want.status), 64'(got.status));
        endfunction
    endclass

    // Block inputs start at known values.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_rx_byte      = 8'd0;
    logic        i_end_of_frame = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [15:0] i_cfg_wr_data  = 16'd0;
    logic        i_out_stall    = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_out_kind;
    logic [3:0]  o_version;
    logic [3:0]  o_msg_type;
    logic [3:0]  o_qos;
    logic [3:0]  o_hops;
    logic [31:0] o_group_id;
    logic [31:0] o_sender_id;
    logic [31:0] o_sequence_number;
    logic [15:0] o_payload_length;
    logic [63:0] o_data_word;
    logic        o_last;
    logic [1:0]  o_status;

    frame_scoreboard sb = new();

    // Bytes of the frames waiting to be sent, end-of-frame flag in the top bit.
    logic [8:0] frame_bytes[$];
    int         burst_left = 0;

    message_frame_parser uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .i_end_of_frame    (i_end_of_frame),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_kind        (o_out_kind),
        .o_version         (o_version),
        .o_msg_type        (o_msg_type),
        .o_qos             (o_qos),
        .o_hops            (o_hops),
        .o_group_id        (o_group_id),
        .o_sender_id       (o_sender_id),
        .o_sequence_number (o_sequence_number),
        .o_payload_length  (o_payload_length),
        .o_data_word       (o_data_word),
        .o_last            (o_last),
        .o_status          (o_status)
    );

    // Clock with a period of 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Both channels are observed at the rising edge; inputs are noted before results.
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_byte(i_rx_byte, i_end_of_frame);
            end
            if (o_out_valid && !i_out_stall) begin
                got.kind            = t_kind'(o_out_kind);
                got.version         = o_version;
                got.msg_type        = o_msg_type;
                got.qos             = o_qos;
                got.hops            = o_hops;
                got.group_id        = o_group_id;
                got.sender_id       = o_sender_id;
                got.sequence_number = o_sequence_number;
                got.payload_length  = o_payload_length;
                got.data_word       = o_data_word;
                got.last            = o_last;
                got.status          = t_status'(o_status);
                sb.check_result(got);
            end
        end
    end

    // The receiver stalls in segments of changing character, with an occasional long hold.
    initial begin : receiver
        int seg;
        int seg_len;
        int mode;
        seg = 0;
        forever begin
            if (seg % 12 == 2) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall = 1'b1;
                end
            end else begin
                seg_len = $urandom_range(20, 150);
                mode    = $urandom_range(0, 3);
                for (int c = 0; c < seg_len; c++) begin
                    @(negedge i_clk);
                    case (mode)
                        0: i_out_stall = 1'b0;
                        1: i_out_stall = 1'($urandom_range(0, 1));
                        2: i_out_stall = ($urandom_range(0, 3) == 0);
                        default: i_out_stall = (c % 5 < 2);
                    endcase
                end
            end
            seg++;
        end
    end

    // Run limit.
    initial begin
        #(LIMIT_TIME);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int min_int(int a, int b);
        return (a < b) ? a : b;
    endfunction

    // Random byte, biased toward the all-zero and all-one extremes.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offers one item and holds it until accepted; gaps fall between random bursts.
    task automatic send_item(logic [7:0] b, logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_rx_byte      = b;
        i_end_of_frame = eof;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    task automatic send_frames();
        foreach (frame_bytes[i]) begin
            send_item(frame_bytes[i][7:0], frame_bytes[i][8]);
        end
        frame_bytes.delete();
    endtask

    // Waits until every predicted result has come out and the pipeline has drained.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.max_len  = v;
    endtask

    // Header bytes; fill < 0 gives random content, cut marks the byte that ends the frame.
    task automatic queue_header(logic [15:0] len, int cut, int fill);
        logic [7:0] b;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            if (i == HEADER_BYTES - 2) begin
                b = len[15:8];
            end else if (i == HEADER_BYTES - 1) begin
                b = len[7:0];
            end else begin
                b = (fill < 0) ? rand_byte() : fill[7:0];
            end
            frame_bytes.push_back({(i == cut), b});
            if (i == cut) break;
        end
    endtask

    task automatic queue_bytes(int n, bit eof_last);
        for (int i = 0; i < n; i++) begin
            frame_bytes.push_back({(eof_last && i == n - 1), rand_byte()});
        end
    endtask

    // One frame of a randomly chosen shape under the current length limit.
    task automatic queue_random_frame();
        int  r;
        int  mx;
        int  lim;
        int  n;
        int  cut;
        logic [15:0] len;
        r  = $urandom_range(0, 99);
        mx = int'(sb.max_len);
        if (r >= 50 && r < 60 && mx == 65535) r = 75;
        if (r >= 72 && r < 87 && mx == 0) r = 60;
        if (r < 40 && mx == 0) r = 45;
        if (r < 40) begin
            // Complete frame, sometimes followed by trailing bytes.
            lim = ($urandom_range(0, 19) == 0) ? min_int(mx, 300) : min_int(mx, 24);
            len = 16'($urandom_range(1, lim));
            n   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
            queue_header(len, -1, -1);
            queue_bytes(int'(len), n == 0);
            if (n > 0) queue_bytes(n, 1'b1);
        end else if (r < 50) begin
            // Zero-length payload.
            n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
            queue_header(16'd0, (n == 0) ? HEADER_BYTES - 1 : -1, -1);
            if (n > 0) queue_bytes(n, 1'b1);
        end else if (r < 60) begin
            // Length above the limit, often just above it.
            if ($urandom_range(0, 1) == 0) begin
                len = 16'(min_int(mx + 1 + $urandom_range(0, 2), 65535));
            end else begin
                len = 16'($urandom_range(mx + 1, 65535));
            end
            n = $urandom_range(0, 4);
            queue_header(len, (n == 0) ? HEADER_BYTES - 1 : -1, -1);
            if (n > 0) queue_bytes(n, 1'b1);
        end else if (r < 72) begin
            // Frame that ends inside the header.
            case ($urandom_range(0, 5))
                0: cut = 0;
                1: cut = 21;
                2: cut = 29;
                3: cut = HEADER_BYTES - 2;
                default: cut = $urandom_range(0, HEADER_BYTES - 2);
            endcase
            queue_header(16'($urandom), cut, -1);
        end else if (r < 87) begin
            // Frame that ends inside the payload.
            len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, mx)) :
                                                 16'($urandom_range(1, min_int(mx, 8)));
            if (len == 1) begin
                n = 0;
            end else begin
                n = $urandom_range(0, min_int(int'(len) - 1, 20));
            end
            queue_header(len, (n == 0) ? HEADER_BYTES - 1 : -1, -1);
            if (n > 0) queue_bytes(n, 1'b1);
        end else begin
            // Noise bytes with scattered frame ends.
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                frame_bytes.push_back({(i == n - 1) || ($urandom_range(0, 3) == 0),
                                       rand_byte()});
            end
        end
    endtask

    // Main sequence: reset, directed frames, then random phases under changing limits.
    initial begin : stimulus
        int          start_items;
        int          ph_idx;
        logic [15:0] v;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset limit: a one-byte frame, then an all-ones header that is too long.
        frame_bytes.push_back({1'b1, 8'h5A});
        queue_header(16'hFFFF, HEADER_BYTES - 1, 255);
        send_frames();
        settle();

        // Zero limit: an all-zero header with zero length is still accepted.
        write_max(16'd0);
        queue_header(16'd0, HEADER_BYTES - 1, 0);
        send_frames();
        settle();

        start_items = sb.live_items;
        ph_idx      = 0;
        while (sb.live_items < start_items + RANDOM_ITEMS) begin
            case (ph_idx)
                0: v = 16'hFFFF;
                1: v = 16'd1;
                default: begin
                    case ($urandom_range(0, 7))
                        0: v = 16'($urandom_range(0, 3));
                        1, 2: v = 16'($urandom_range(4, 40));
                        3: v = 16'hFFFF;
                        4: v = 16'($urandom);
                        default: v = 16'($urandom_range(10, 30));
                    endcase
                end
            endcase
            write_max(v);
            repeat ($urandom_range(3, 8)) queue_random_frame();
            send_frames();
            settle();
            ph_idx++;
        end

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
